/* rtl/ordered_array_insert_delete_store_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef ORDERED_ARRAY_INSERT_DELETE_STORE_TOP_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_STORE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OAIDS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed: same-cycle rule");

// Next-cycle implication, checked on every rising edge outside reset.
`define OAIDS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed: next-cycle rule");

`endif

/* rtl/oaids_pkg.sv */
package oaids_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int REQ_W  = 3;
  localparam int IDX_W  = 16;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_GET    = 3'd3,
    REQ_RESIZE = 3'd4,
    REQ_CLEAR  = 3'd5
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_INDEX = 2'd1,
    STAT_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [IDX_W-1:0]  index;
    logic [IDX_W-1:0]  length;
    logic [WORD_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [WORD_W-1:0] read_value;
    logic [OCNT_W-1:0] element_count;
  } out_item_t;

  // Broadcast command to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUT,
    CELL_LOAD,
    CELL_SHIFT,
    CELL_COMMIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  lim;
    logic [WORD_W-1:0] value;
  } cell_ctl_t;

endpackage

/* rtl/oaids_cell.sv */
module oaids_cell #(
  parameter int POS = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  oaids_pkg::cell_ctl_t      ctl,
  input  logic [oaids_pkg::WORD_W-1:0] left_data,
  input  logic [oaids_pkg::WORD_W-1:0] right_shadow,
  output logic [oaids_pkg::WORD_W-1:0] data,
  output logic [oaids_pkg::WORD_W-1:0] shadow
);
  import oaids_pkg::*;

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(POS);

  // Stored word; cleared by reset since a grow can expose it.
  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else begin
      case (ctl.op)
        CELL_PUT: begin
          if (MY_POS == ctl.idx) begin
            data <= ctl.value;
          end else if ((MY_POS > ctl.idx) && (MY_POS <= ctl.lim)) begin
            data <= left_data;
          end
        end
        CELL_COMMIT: begin
          if ((MY_POS >= ctl.idx) && (MY_POS < ctl.lim)) begin
            data <= shadow;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Shadow copy walks toward position zero one step a cycle.
  always_ff @(posedge clk) begin
    case (ctl.op)
      CELL_LOAD:  shadow <= data;
      CELL_SHIFT: shadow <= right_shadow;
      default: begin
      end
    endcase
  end

endmodule

/* rtl/ordered_array_insert_delete_store_top.sv */
// Sequence: append, insert, resize, clear, failed requests and truncating deletes
//   strobe done from the DECIDE state; get at index i and a closing delete of
//   length n walk the shadow copy in SHIFT as far as needed and strobe done from FINISH.
// Flow: one request at a time; busy holds until done, so no new request is taken before.
// Reset: synchronous; count and every stored word clear together, no sweep.
// Results appear for one cycle on done; the receiver cannot stall them.
module ordered_array_insert_delete_store_top #(
  parameter int CAPACITY = oaids_pkg::CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  oaids_pkg::in_item_t  request,
  output logic                 done,
  output oaids_pkg::out_item_t result
);
  import oaids_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SH_W  = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t              state;
  logic [CNT_W-1:0]    count;
  logic [REQ_W-1:0]    req_q;
  logic [IDX_W-1:0]    idx_q;
  logic [IDX_W-1:0]    len_q;
  logic [WORD_W-1:0]   val_q;
  logic [SH_W-1:0]     shift_left;

  // Decision made in the DECIDE cycle.
  status_t             dec_status;
  logic [CNT_W-1:0]    dec_count;
  logic                dec_walk;
  logic [SH_W-1:0]     dec_shift;
  cell_op_t            dec_op;
  logic [IDX_W-1:0]    dec_idx;

  logic [IDX_W-1:0]    count_ext;
  logic [IDX_W:0]      del_end;
  logic                full;
  logic [CNT_W-1:0]    del_count;

  cell_ctl_t           ctl;
  logic [WORD_W-1:0]   cell_data   [CAPACITY];
  logic [WORD_W-1:0]   cell_shadow [CAPACITY];

  assign busy      = (state != S_IDLE);
  assign count_ext = IDX_W'(count);
  assign del_end   = {1'b0, idx_q} + {1'b0, len_q};
  assign full      = (count == CAP_CNT);
  assign del_count = count - CNT_W'(len_q);

  always_comb begin
    dec_status = STAT_OK;
    dec_count  = count;
    dec_walk   = 1'b0;
    dec_shift  = '0;
    dec_op     = CELL_HOLD;
    dec_idx    = idx_q;
    case (req_q)
      REQ_APPEND: begin
        if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_op    = CELL_PUT;
          dec_idx   = count_ext;
          dec_count = count + CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        if (idx_q > count_ext) begin
          dec_status = STAT_BAD_INDEX;
        end else if (full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_op    = CELL_PUT;
          dec_count = count + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (idx_q >= count_ext) begin
          dec_status = STAT_BAD_INDEX;
        end else if (del_end >= (IDX_W + 1)'(count)) begin
          // range reaches the end: truncate
          dec_count = CNT_W'(idx_q);
        end else if (len_q != '0) begin
          dec_walk  = 1'b1;
          dec_op    = CELL_LOAD;
          dec_shift = SH_W'(len_q);
        end
      end
      REQ_GET: begin
        if (idx_q >= count_ext) begin
          dec_status = STAT_BAD_INDEX;
        end else begin
          dec_walk  = 1'b1;
          dec_op    = CELL_LOAD;
          dec_shift = SH_W'(idx_q);
        end
      end
      REQ_RESIZE: begin
        if (idx_q > IDX_W'(CAPACITY)) begin
          dec_status = STAT_FULL;
        end else begin
          dec_count = CNT_W'(idx_q);
        end
      end
      REQ_CLEAR: begin
        dec_count = '0;
      end
      default: begin
        dec_status = STAT_BAD_INDEX;
      end
    endcase
  end

  // Drive the broadcast command for the row of cells.
  always_comb begin
    ctl.op    = CELL_HOLD;
    ctl.idx   = dec_idx;
    ctl.lim   = count_ext;
    ctl.value = val_q;
    case (state)
      S_DECIDE: ctl.op = dec_op;
      S_SHIFT:  ctl.op = CELL_SHIFT;
      S_FINISH: begin
        if (req_q == REQ_DELETE) begin
          ctl.op  = CELL_COMMIT;
          ctl.lim = IDX_W'(del_count);
        end
      end
      default: ctl.op = CELL_HOLD;
    endcase
  end

  // Sequencer: hold state, count, latched request and the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= request.req_type;
            idx_q <= request.index;
            len_q <= request.length;
            val_q <= request.value;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (dec_walk) begin
            shift_left <= dec_shift;
            state      <= (dec_shift == '0) ? S_FINISH : S_SHIFT;
          end else begin
            count                <= dec_count;
            done                 <= 1'b1;
            result.status        <= dec_status;
            result.read_value    <= '0;
            result.element_count <= OCNT_W'(dec_count);
            state                <= S_IDLE;
          end
        end
        S_SHIFT: begin
          shift_left <= shift_left - SH_W'(1);
          if (shift_left == SH_W'(1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          done          <= 1'b1;
          result.status <= STAT_OK;
          if (req_q == REQ_DELETE) begin
            // close the gap: the committed cells take the walked copy
            count                <= del_count;
            result.read_value    <= '0;
            result.element_count <= OCNT_W'(del_count);
          end else begin
            // walked copy of the requested word sits at position zero
            result.read_value    <= cell_shadow[0];
            result.element_count <= OCNT_W'(count);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Row of cells: each word hands data up on insert and its shadow down on a walk.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_shadow[i+1];
    end
    oaids_cell #(
      .POS(i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (ctl),
      .left_data    (left_w),
      .right_shadow (right_w),
      .data         (cell_data[i]),
      .shadow       (cell_shadow[i])
    );
  end

endmodule

/* rtl/oaids_checker.sv */
module oaids_checker #(
  parameter int CAPACITY = oaids_pkg::CAPACITY_DEF
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input oaids_pkg::out_item_t result
);
  import oaids_pkg::*;

`include "ordered_array_insert_delete_store_top_defines.svh"

  // A result beat leaves the block ready for the next request.
  `OAIDS_ASSERT_NOW(a_done_idle, done, !busy)
  // An accepted request holds the block busy in the following cycle.
  `OAIDS_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done)
  // A failed request never returns a word.
  `OAIDS_ASSERT_NOW(a_fail_zero, done && (result.status != STAT_OK), result.read_value == '0)
  // The reported count never passes the capacity.
  `OAIDS_ASSERT_NOW(a_count_cap, done, int'(result.element_count) <= CAPACITY)

endmodule

bind ordered_array_insert_delete_store_top oaids_checker #(
  .CAPACITY(CAPACITY)
) u_oaids_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
